// ----- src/ple_pkg.sv -----
// Shared constants and types for the positional list engine.
`timescale 1ns / 1ps

package ple_pkg;

	localparam int DEF_CAPACITY = 64;
	localparam int VAL_W        = 32;
	localparam int POS_W        = 8;
	localparam int CNT_OUT_W    = 7;
	// Wide enough for any position and for a count of up to 256 entries.
	localparam int CMP_W        = 9;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_READ   = 2'd2;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_ABSENT = 2'd2;

	// Operation broadcast to every cell of the chain.
	typedef struct packed {
		logic             ins_en;
		logic             rem_en;
		logic             rd_en;
		logic [CMP_W-1:0] pos;
	} ple_op_t;

endpackage

// ----- src/ple_cell.sv -----
// One storage cell of the list chain; holds the entry for a fixed list position.
`timescale 1ns / 1ps

module ple_cell #(
	parameter int IDX = 0
) (
	input  logic                       clk,
	input  ple_pkg::ple_op_t           op,
	input  logic [ple_pkg::VAL_W-1:0]  value_in,
	input  logic [ple_pkg::VAL_W-1:0]  left_data,
	input  logic [ple_pkg::VAL_W-1:0]  right_data,
	output logic [ple_pkg::VAL_W-1:0]  data,
	output logic [ple_pkg::VAL_W-1:0]  rd_data
);

	localparam logic [ple_pkg::CMP_W-1:0] MY_IDX = ple_pkg::CMP_W'(IDX);

	logic [ple_pkg::VAL_W-1:0] data_q;
	logic                      above;
	logic                      here;

	assign above = MY_IDX > op.pos;
	assign here  = MY_IDX == op.pos;

	// Insert moves the tail one place right; remove pulls it one place left.
	always_ff @(posedge clk) begin
		if (op.ins_en && above) begin
			data_q <= left_data;
		end else if (op.ins_en && here) begin
			data_q <= value_in;
		end else if (op.rem_en && (above || here)) begin
			data_q <= right_data;
		end
	end

	assign data    = data_q;
	assign rd_data = (op.rd_en && here) ? data_q : '0;

endmodule

// ----- src/ple_ctrl.sv -----
// Command decode, bounds checks and entry count for the positional list engine.
`timescale 1ns / 1ps

module ple_ctrl #(
	parameter int CAPACITY = ple_pkg::DEF_CAPACITY,
	parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      fire,
	input  logic [1:0]                command,
	input  logic [ple_pkg::POS_W-1:0] position,
	output ple_pkg::ple_op_t          op,
	output logic [1:0]                status_nx,
	output logic [CNT_W-1:0]          count_nx
);

	localparam logic [ple_pkg::CMP_W-1:0] CAP_C = ple_pkg::CMP_W'(CAPACITY);

	logic [CNT_W-1:0]          count_q;
	logic [ple_pkg::CMP_W-1:0] cnt_c;
	logic [ple_pkg::CMP_W-1:0] pos_c;
	logic                      full;
	logic                      present;

	assign cnt_c   = ple_pkg::CMP_W'(count_q);
	assign pos_c   = ple_pkg::CMP_W'(position);
	assign full    = cnt_c >= CAP_C;
	assign present = pos_c < cnt_c;

	always_comb begin
		op        = '0;
		op.pos    = pos_c;
		status_nx = ple_pkg::ST_OK;
		count_nx  = count_q;
		unique case (command) inside
			ple_pkg::CMD_INSERT: begin
				// A position past the end appends.
				if (pos_c > cnt_c) begin
					op.pos = cnt_c;
				end
				if (full) begin
					status_nx = ple_pkg::ST_FULL;
				end else begin
					op.ins_en = fire;
					count_nx  = count_q + CNT_W'(1);
				end
			end
			ple_pkg::CMD_REMOVE, ple_pkg::CMD_READ: begin
				if (!present) begin
					status_nx = ple_pkg::ST_ABSENT;
				end else begin
					op.rd_en = 1'b1;
					if (command == ple_pkg::CMD_REMOVE) begin
						op.rem_en = fire;
						count_nx  = count_q - CNT_W'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (fire) begin
			count_q <= count_nx;
		end
	end

endmodule

// ----- src/positional_list_engine_top.sv -----
// Top level of the positional list engine: cell chain, control and result register.
//
//   channel | signals                                    | direction
//   --------+--------------------------------------------+----------
//   input   | in_valid, in_stall, command, position,     | in
//           | value_in                                   |
//   output  | out_valid, out_stall, value_out,           | out
//           | entry_count, status                        |
//
// Each transaction executes in the cycle it is accepted: every cell of the chain
// shifts, loads or holds in parallel, and the result is registered at that edge,
// so one transaction per cycle is sustained while the output is taken.
// The input stalls only while a registered result is held by out_stall.
// Reset clears the entry count and the output valid; cell contents are not reset.
`timescale 1ns / 1ps

module positional_list_engine_top #(
	parameter int CAPACITY = ple_pkg::DEF_CAPACITY
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    command,
	input  logic [ple_pkg::POS_W-1:0]     position,
	input  logic signed [ple_pkg::VAL_W-1:0] value_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [ple_pkg::VAL_W-1:0] value_out,
	output logic [ple_pkg::CNT_OUT_W-1:0] entry_count,
	output logic [1:0]                    status
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic                          fire;
	logic                          out_valid_q;
	logic [ple_pkg::VAL_W-1:0]     value_out_q;
	logic [ple_pkg::CNT_OUT_W-1:0] entry_count_q;
	logic [1:0]                    status_q;
	ple_pkg::ple_op_t              op;
	logic [1:0]                    status_nx;
	logic [CNT_W-1:0]              count_nx;
	logic [CNT_W+ple_pkg::CNT_OUT_W-1:0] count_ext;
	logic [ple_pkg::VAL_W-1:0]     cell_data [CAPACITY];
	logic [ple_pkg::VAL_W-1:0]     cell_rd   [CAPACITY];
	logic [ple_pkg::VAL_W-1:0]     rd_value;

	assign in_stall = out_valid_q && out_stall;
	assign fire     = in_valid && !in_stall;

	ple_ctrl #(
		.CAPACITY (CAPACITY),
		.CNT_W    (CNT_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.command   (command),
		.position  (position),
		.op        (op),
		.status_nx (status_nx),
		.count_nx  (count_nx)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [ple_pkg::VAL_W-1:0] left_data;
		logic [ple_pkg::VAL_W-1:0] right_data;

		if (i == 0) begin : g_first
			assign left_data = '0;
		end else begin : g_inner_l
			assign left_data = cell_data[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_data = cell_data[i];
		end else begin : g_inner_r
			assign right_data = cell_data[i+1];
		end

		ple_cell #(
			.IDX (i)
		) u_cell (
			.clk        (clk),
			.op         (op),
			.value_in   (value_in),
			.left_data  (left_data),
			.right_data (right_data),
			.data       (cell_data[i]),
			.rd_data    (cell_rd[i])
		);
	end

	// At most one cell drives a nonzero read value.
	always_comb begin
		rd_value = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_value = rd_value | cell_rd[i];
		end
	end

	assign count_ext = {{ple_pkg::CNT_OUT_W{1'b0}}, count_nx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			value_out_q   <= rd_value;
			entry_count_q <= count_ext[ple_pkg::CNT_OUT_W-1:0];
			status_q      <= status_nx;
		end
	end

	assign out_valid   = out_valid_q;
	assign value_out   = value_out_q;
	assign entry_count = entry_count_q;
	assign status      = status_q;

endmodule

// ----- test/tb_positional_list_engine_top.sv -----
// Self-checking testbench for the positional list engine: directed table, then random list traffic.
`timescale 1ns / 1ps

module tb_positional_list_engine_top;

	localparam int CAPACITY = ple_pkg::DEF_CAPACITY;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 10;
	localparam logic [1:0] CMD_NOP = 2'd3;
	localparam int NUM_ROWS = 21;
	localparam int ITEMS_PER_SEGMENT = 95;

	typedef enum int {SEG_GROW, SEG_MIX, SEG_SHRINK} segment_t;

	typedef struct packed {
		logic [ple_pkg::VAL_W-1:0]     value_out;
		logic [ple_pkg::CNT_OUT_W-1:0] entry_count;
		logic [1:0]                    status;
	} list_result_t;

	typedef struct packed {
		logic [1:0]                cmd;
		logic [ple_pkg::POS_W-1:0] pos;
		logic [ple_pkg::VAL_W-1:0] val;
		logic                      fixed;
		list_result_t              res;
	} table_row_t;

	logic                             clk = 1'b0;
	logic                             arst_n;
	logic                             in_valid;
	logic                             in_stall;
	logic [1:0]                       command;
	logic [ple_pkg::POS_W-1:0]        position;
	logic signed [ple_pkg::VAL_W-1:0] value_in;
	logic                             out_valid;
	logic                             out_stall;
	logic signed [ple_pkg::VAL_W-1:0] value_out;
	logic [ple_pkg::CNT_OUT_W-1:0]    entry_count;
	logic [1:0]                       status;

	// Shadow copy of the list contents as the block should hold them.
	logic [ple_pkg::VAL_W-1:0] shadow_cells [CAPACITY];
	int unsigned               shadow_count;

	list_result_t pending_results [$];
	list_result_t predicted;
	logic         row_fixed;
	list_result_t row_res;
	int           fail_count;
	int           idle_cycles;
	int           sender_idle_pct;
	int           stall_pct;

	table_row_t directed_rows [NUM_ROWS] = '{
		'{ple_pkg::CMD_READ,   8'd0,   32'h0000_0000, 1'b1,
			'{32'h0000_0000, 7'd0, ple_pkg::ST_ABSENT}},
		'{ple_pkg::CMD_REMOVE, 8'd255, 32'h0000_0000, 1'b1,
			'{32'h0000_0000, 7'd0, ple_pkg::ST_ABSENT}},
		'{CMD_NOP,             8'd255, 32'hFFFF_FFFF, 1'b1,
			'{32'h0000_0000, 7'd0, ple_pkg::ST_OK}},
		'{ple_pkg::CMD_INSERT, 8'd255, 32'h7FFF_FFFF, 1'b1,
			'{32'h0000_0000, 7'd1, ple_pkg::ST_OK}},
		'{ple_pkg::CMD_INSERT, 8'd0,   32'h8000_0000, 1'b1,
			'{32'h0000_0000, 7'd2, ple_pkg::ST_OK}},
		'{ple_pkg::CMD_INSERT, 8'd1,   32'hFFFF_FFFF, 1'b1,
			'{32'h0000_0000, 7'd3, ple_pkg::ST_OK}},
		'{ple_pkg::CMD_READ,   8'd0,   32'h1234_5678, 1'b1,
			'{32'h8000_0000, 7'd3, ple_pkg::ST_OK}},
		'{ple_pkg::CMD_READ,   8'd2,   32'h0000_0000, 1'b1,
			'{32'h7FFF_FFFF, 7'd3, ple_pkg::ST_OK}},
		'{ple_pkg::CMD_READ,   8'd3,   32'h0000_0000, 1'b1,
			'{32'h0000_0000, 7'd3, ple_pkg::ST_ABSENT}},
		'{ple_pkg::CMD_READ,   8'd1,   32'h0000_0000, 1'b0, '0},
		'{ple_pkg::CMD_INSERT, 8'd3,   32'h0000_0000, 1'b0, '0},
		'{ple_pkg::CMD_INSERT, 8'd2,   32'h5A5A_5A5A, 1'b0, '0},
		'{ple_pkg::CMD_REMOVE, 8'd4,   32'hA5A5_A5A5, 1'b0, '0},
		'{ple_pkg::CMD_REMOVE, 8'd0,   32'h0000_0000, 1'b0, '0},
		'{ple_pkg::CMD_READ,   8'd255, 32'h0000_0000, 1'b1,
			'{32'h0000_0000, 7'd3, ple_pkg::ST_ABSENT}},
		'{CMD_NOP,             8'd0,   32'h0000_0000, 1'b0, '0},
		'{ple_pkg::CMD_REMOVE, 8'd1,   32'h0000_0000, 1'b0, '0},
		'{ple_pkg::CMD_REMOVE, 8'd0,   32'h0000_0000, 1'b0, '0},
		'{ple_pkg::CMD_REMOVE, 8'd0,   32'h0000_0000, 1'b0, '0},
		'{ple_pkg::CMD_REMOVE, 8'd0,   32'h0000_0000, 1'b1,
			'{32'h0000_0000, 7'd0, ple_pkg::ST_ABSENT}},
		'{ple_pkg::CMD_INSERT, 8'd128, 32'h0000_0001, 1'b1,
			'{32'h0000_0000, 7'd1, ple_pkg::ST_OK}}
	};

	positional_list_engine_top #(
		.CAPACITY(CAPACITY)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.position   (position),
		.value_in   (value_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.value_out  (value_out),
		.entry_count(entry_count),
		.status     (status)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic list_result_t apply_list_op(input logic [1:0] cmd,
			input logic [ple_pkg::POS_W-1:0] pos, input logic [ple_pkg::VAL_W-1:0] val);
		list_result_t r;
		int unsigned  p;
		int unsigned  i;
		r = '0;
		p = pos;
		case (cmd) inside
			ple_pkg::CMD_INSERT: begin
				if (shadow_count >= CAPACITY) begin
					r.status = ple_pkg::ST_FULL;
				end else begin
					// Positions past the end append.
					if (p > shadow_count)
						p = shadow_count;
					for (i = shadow_count; i > p; i--)
						shadow_cells[i] = shadow_cells[i-1];
					shadow_cells[p] = val;
					shadow_count++;
				end
			end
			ple_pkg::CMD_REMOVE, ple_pkg::CMD_READ: begin
				if (p >= shadow_count) begin
					r.status = ple_pkg::ST_ABSENT;
				end else begin
					r.value_out = shadow_cells[p];
					if (cmd == ple_pkg::CMD_REMOVE) begin
						for (i = p; i + 1 < shadow_count; i++)
							shadow_cells[i] = shadow_cells[i+1];
						shadow_count--;
					end
				end
			end
			default: begin
			end
		endcase
		r.entry_count = ple_pkg::CNT_OUT_W'(shadow_count);
		return r;
	endfunction

	task automatic check_result(input list_result_t e);
		if (value_out !== e.value_out) begin
			$error("value_out: expected %0d, got %0d", $signed(e.value_out), value_out);
			fail_count++;
		end
		if (entry_count !== e.entry_count) begin
			$error("entry_count: expected %0d, got %0d", e.entry_count, entry_count);
			fail_count++;
		end
		if (status !== e.status) begin
			$error("status: expected %0d, got %0d", e.status, status);
			fail_count++;
		end
	endtask

	// Results are compared before the new transaction is predicted, since a result
	// accepted at this edge belongs to an earlier transaction.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					$error("unexpected result: value_out %0d, entry_count %0d, status %0d",
						value_out, entry_count, status);
					fail_count++;
				end else begin
					check_result(pending_results.pop_front());
				end
			end
			if (in_valid && !in_stall) begin
				predicted = apply_list_op(command, position, value_in);
				pending_results.push_back(row_fixed ? row_res : predicted);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("positional_list_engine_top: mismatch");
				$finish;
			end
		end
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	task automatic send_item(input logic [1:0] cmd, input logic [ple_pkg::POS_W-1:0] pos,
			input logic [ple_pkg::VAL_W-1:0] val, input logic fixed,
			input list_result_t fixed_res);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		command   <= cmd;
		position  <= pos;
		value_in  <= val;
		row_fixed = fixed;
		row_res   = fixed_res;
		in_valid  <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic make_list_op(input segment_t seg, output logic [1:0] cmd,
			output logic [ple_pkg::POS_W-1:0] pos, output logic [ple_pkg::VAL_W-1:0] val);
		int r;
		int ins_pct;
		int rem_pct;
		int rd_pct;
		case (seg)
			SEG_GROW:   begin ins_pct = 85; rem_pct = 10; rd_pct = 3;  end
			SEG_SHRINK: begin ins_pct = 10; rem_pct = 75; rd_pct = 12; end
			default:    begin ins_pct = 35; rem_pct = 30; rd_pct = 30; end
		endcase
		r = $urandom_range(99);
		if (r < ins_pct)
			cmd = ple_pkg::CMD_INSERT;
		else if (r < ins_pct + rem_pct)
			cmd = ple_pkg::CMD_REMOVE;
		else if (r < ins_pct + rem_pct + rd_pct)
			cmd = ple_pkg::CMD_READ;
		else
			cmd = CMD_NOP;
		// Positions cluster around the live range, with the edges and the full field mixed in.
		r = $urandom_range(9);
		if (r <= 5)
			pos = ple_pkg::POS_W'($urandom_range(shadow_count));
		else if (r == 6)
			pos = '0;
		else if (r == 7)
			pos = (shadow_count > 0) ? ple_pkg::POS_W'(shadow_count - 1) : '0;
		else
			pos = ple_pkg::POS_W'($urandom_range(255));
		case ($urandom_range(15))
			0:       val = 32'h7FFF_FFFF;
			1:       val = 32'h8000_0000;
			2:       val = 32'h0000_0000;
			3:       val = 32'hFFFF_FFFF;
			default: val = $urandom;
		endcase
	endtask

	initial begin
		int                        sender_pcts [4];
		int                        stall_pcts [4];
		logic [1:0]                cmd;
		logic [ple_pkg::POS_W-1:0] pos;
		logic [ple_pkg::VAL_W-1:0] val;
		sender_pcts = '{0, 86, 0, 16};
		stall_pcts  = '{0, 0, 86, 16};
		arst_n          = 1'b0;
		in_valid        = 1'b0;
		command         = ple_pkg::CMD_INSERT;
		position        = '0;
		value_in        = '0;
		out_stall       = 1'b0;
		row_fixed       = 1'b0;
		row_res         = '0;
		fail_count      = 0;
		idle_cycles     = 0;
		sender_idle_pct = 0;
		stall_pct       = 0;
		shadow_count    = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[n])
			send_item(directed_rows[n].cmd, directed_rows[n].pos, directed_rows[n].val,
				directed_rows[n].fixed, directed_rows[n].res);

		for (int ph = 0; ph < 4; ph++) begin
			sender_idle_pct = sender_pcts[ph];
			stall_pct       = stall_pcts[ph];
			for (int s = SEG_GROW; s <= SEG_SHRINK; s++) begin
				for (int k = 0; k < ITEMS_PER_SEGMENT; k++) begin
					make_list_op(segment_t'(s), cmd, pos, val);
					send_item(cmd, pos, val, 1'b0, '0);
				end
			end
			// Hold the sender off until every outstanding transaction has returned.
			in_valid <= 1'b0;
			while (pending_results.size() != 0)
				@(negedge clk);
		end

		stall_pct = 0;
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0 && pending_results.size() == 0)
			$display("positional_list_engine_top: match");
		else
			$display("positional_list_engine_top: mismatch");
		$finish;
	end

endmodule
